FILE: src/sgoc_pkg.sv
package sgoc_pkg;

  localparam int COORD_W = 10;
  localparam int TOTAL_W = 21;
  localparam int COVER_W = 2;

  localparam logic [COVER_W-1:0] COVER_SAT = COVER_W'(2);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic [COORD_W-1:0] y_end;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_start;
  } seg_t;

endpackage

FILE: src/sgoc_ram.sv
module sgoc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1048576
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/segment_grid_overlap_counter.sv
// Grid line segment overlap counter.
// Input stream: one segment per transfer on in_*, end points (x_start, y_start)
// and (x_end, y_end). Output stream: one result per segment on out_*, the
// running count of grid points covered at least twice, and a reject flag in
// out_tuser for segments off the grid or not horizontal, vertical or diagonal.
// Coverage counters live in a GRID_DIM*GRID_DIM x 2-bit RAM. An accepted
// segment is walked one grid point per cycle (read, then increment and write
// back the next cycle). The walk is followed by ST_DRAIN and ST_DONE; on
// leaving ST_DONE the result is registered and out_tvalid rises, and the next
// segment can be taken in the same cycle as the first result offer. A rejected
// segment goes from idle straight to ST_DONE without walking.
// The block works on one segment at a time; in_tready is high only while idle.
// The result waits in an output register, so a stalled receiver does not hold
// off the next segment; once that one is finished it waits for out_tready
// and in_tready stays low.
// After reset the RAM is cleared one entry per cycle, all GRID_DIM*GRID_DIM
// entries, while in_tready stays low; the overlap total is reset to zero.
module segment_grid_overlap_counter #(
  parameter int GRID_DIM = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // x_start[9:0], y_start[19:10], x_end[29:20], y_end[39:30]
  input  logic [sgoc_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // overlap_total[20:0], zero fill [23:21]
  output logic [sgoc_pkg::OUT_DATA_W-1:0] out_tdata,
  // rejected[0]
  output logic                          out_tuser
);

  import sgoc_pkg::*;

  localparam int DEPTH = GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = $clog2(GRID_DIM + 1);
  localparam int CMP_W = (DW > COORD_W) ? DW : COORD_W;

  localparam logic [CMP_W-1:0] DIM_C  = CMP_W'(GRID_DIM);
  localparam logic [AW-1:0]    DIM_A  = AW'(GRID_DIM);
  localparam logic [AW-1:0]    LAST_A = AW'(DEPTH - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [AW-1:0]      clr_r;
  logic [COORD_W-1:0] x_r, y_r, cnt_r;
  logic               x_inc_r, x_dec_r, y_inc_r, y_dec_r;
  logic               bad_r;
  logic               rd_pend_r;
  logic [AW-1:0]      wr_addr_r;
  logic [TOTAL_W-1:0] total_r;
  logic               out_tvalid_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic               out_rej_r;

  seg_t               seg;
  logic [COORD_W-1:0] adx, ady, len;
  logic               in_bad;
  logic               in_xfer;
  logic               out_free;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [COVER_W-1:0] ram_wdata, ram_rdata;
  logic [COVER_W-1:0] cov_inc;
  logic               cov_upd;

  assign seg      = seg_t'(in_tdata);
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    adx = (seg.x_end >= seg.x_start) ? seg.x_end - seg.x_start : seg.x_start - seg.x_end;
    ady = (seg.y_end >= seg.y_start) ? seg.y_end - seg.y_start : seg.y_start - seg.y_end;
    len = (adx > ady) ? adx : ady;
    in_bad = (CMP_W'(seg.x_start) >= DIM_C) || (CMP_W'(seg.y_start) >= DIM_C) ||
             (CMP_W'(seg.x_end) >= DIM_C) || (CMP_W'(seg.y_end) >= DIM_C) ||
             ((adx != '0) && (ady != '0) && (adx != ady));
  end

  // y * GRID_DIM + x for the point being read
  assign ram_raddr = AW'(AW'(y_r) * DIM_A) + AW'(x_r);

  assign cov_upd = rd_pend_r && (ram_rdata < COVER_SAT);
  assign cov_inc = ram_rdata + COVER_W'(1);

  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = cov_upd;
      ram_waddr = wr_addr_r;
      ram_wdata = cov_inc;
    end
  end

  sgoc_ram #(
    .WIDTH(COVER_W),
    .DEPTH(DEPTH)
  ) u_cov_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == LAST_A) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_xfer) state_nxt = in_bad ? ST_DONE : ST_WALK;
      ST_WALK:  if (cnt_r == '0) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      rd_pend_r    <= 1'b0;
      total_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      rd_pend_r <= (state_r == ST_WALK);
      if (cov_upd && (cov_inc == COVER_SAT) && (total_r != TOTAL_MAX)) begin
        total_r <= total_r + TOTAL_W'(1);
      end
      if (state_r == ST_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_r     <= seg.x_start;
      y_r     <= seg.y_start;
      cnt_r   <= len;
      x_inc_r <= seg.x_end > seg.x_start;
      x_dec_r <= seg.x_end < seg.x_start;
      y_inc_r <= seg.y_end > seg.y_start;
      y_dec_r <= seg.y_end < seg.y_start;
      bad_r   <= in_bad;
    end else if (state_r == ST_WALK) begin
      cnt_r <= cnt_r - COORD_W'(1);
      if (x_inc_r) begin
        x_r <= x_r + COORD_W'(1);
      end else if (x_dec_r) begin
        x_r <= x_r - COORD_W'(1);
      end
      if (y_inc_r) begin
        y_r <= y_r + COORD_W'(1);
      end else if (y_dec_r) begin
        y_r <= y_r - COORD_W'(1);
      end
    end
    wr_addr_r <= ram_raddr;
    if (state_r == ST_DONE && out_free) begin
      out_total_r <= total_r;
      out_rej_r   <= bad_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(OUT_DATA_W - TOTAL_W)'(0), out_total_r};
  assign out_tuser  = out_rej_r;

endmodule

FILE: bench/segment_overlap_checker.sv
`timescale 1ns / 100ps

module segment_overlap_checker #(
  parameter int GRID_DIM = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [sgoc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [sgoc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            out_tuser,
  output int                              mismatch_count,
  output int                              results_due
);

  import sgoc_pkg::*;

  localparam int GRID_CELLS   = GRID_DIM * GRID_DIM;
  localparam int RESULT_SLOTS = 64;

  typedef struct packed {
    logic               rejected;
    logic [TOTAL_W-1:0] total;
  } overlap_result_t;

  bit [COVER_W-1:0]   cover_map [GRID_CELLS];
  logic [TOTAL_W-1:0] doubled_points = '0;
  overlap_result_t    expected_ring [RESULT_SLOTS];
  int                 ring_head = 0;  // next result to compare
  int                 ring_tail = 0;  // next free slot
  int                 fail_tally = 0;
  int                 due = 0;

  assign mismatch_count = fail_tally;
  assign results_due    = due;

  // Checks the segment and, if accepted, walks it point by point and bumps each coverage counter below saturation.
  function automatic overlap_result_t trace_segment(seg_t s);
    int x0, y0, x1, y1, adx, ady, span, x, y, idx;
    overlap_result_t res;
    x0  = int'(s.x_start);
    y0  = int'(s.y_start);
    x1  = int'(s.x_end);
    y1  = int'(s.y_end);
    adx = (x1 >= x0) ? x1 - x0 : x0 - x1;
    ady = (y1 >= y0) ? y1 - y0 : y0 - y1;
    res.rejected = (x0 >= GRID_DIM) || (y0 >= GRID_DIM) || (x1 >= GRID_DIM) ||
                   (y1 >= GRID_DIM) || (adx != 0 && ady != 0 && adx != ady);
    if (!res.rejected) begin
      span = (adx > ady) ? adx : ady;
      x = x0;
      y = y0;
      for (int i = 0; i <= span; i++) begin
        idx = y * GRID_DIM + x;
        if (cover_map[idx] < COVER_SAT) begin
          cover_map[idx] = cover_map[idx] + 1'b1;
          if (cover_map[idx] == COVER_SAT && doubled_points != TOTAL_MAX)
            doubled_points = doubled_points + 1'b1;
        end
        x += (x1 > x0) ? 1 : (x1 < x0) ? -1 : 0;
        y += (y1 > y0) ? 1 : (y1 < y0) ? -1 : 0;
      end
    end
    res.total = doubled_points;
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    overlap_result_t want;
    int errs;
    errs = 0;
    if (rst_n && out_tvalid && out_tready) begin
      if (ring_tail == ring_head) begin
        $display("%0t: unexpected result, expected none, got total %0d rejected %0b",
                 $time, out_tdata, out_tuser);
        errs++;
      end else begin
        want = expected_ring[ring_head % RESULT_SLOTS];
        ring_head++;
        if (out_tdata !== OUT_DATA_W'(want.total)) begin
          $display("%0t: overlap_total mismatch, expected %0d, got %0d",
                   $time, want.total, out_tdata);
          errs++;
        end
        if (out_tuser !== want.rejected) begin
          $display("%0t: rejected mismatch, expected %0b, got %0b",
                   $time, want.rejected, out_tuser);
          errs++;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      expected_ring[ring_tail % RESULT_SLOTS] = trace_segment(seg_t'(in_tdata));
      ring_tail++;
    end
    fail_tally <= fail_tally + errs;
    due        <= ring_tail - ring_head;
  end

endmodule

FILE: bench/segment_grid_overlap_counter_tb.sv
`timescale 1ns / 100ps

module segment_grid_overlap_counter_tb;
  import sgoc_pkg::*;

  localparam int GRID_DIM        = 1024;
  localparam int COORD_MAX       = (1 << COORD_W) - 1;
  localparam int RESET_CYCLES    = 10;
  localparam int SEGMENTS_PER_RUN = 187;
  localparam int HOT_SPAN        = 63;
  localparam int SHORT_LEN_MAX   = 40;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = GRID_DIM + 64;
  // RAM clear after reset alone covers all GRID_DIM^2 entries with no transfers
  localparam int WATCHDOG_LIMIT  = 4 * GRID_DIM * GRID_DIM;

  typedef enum logic [1:0] {
    RX_HEAVY_STALL,
    TX_HEAVY_GAPS,
    NO_IDLE
  } idle_mode_e;

  typedef enum logic [2:0] {
    EAST, WEST, NORTH, SOUTH, NORTH_EAST, NORTH_WEST, SOUTH_EAST, SOUTH_WEST
  } heading_e;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  int                    mismatch_count;
  int                    results_due;
  idle_mode_e            idle_mode    = RX_HEAVY_STALL;
  bit                    hold_request = 1'b0;
  int                    quiet_cycles = 0;

  segment_grid_overlap_counter #(.GRID_DIM(GRID_DIM)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  segment_overlap_checker #(.GRID_DIM(GRID_DIM)) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .mismatch_count(mismatch_count),
    .results_due   (results_due)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : receiver
    int stall_pct;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      case (idle_mode)
        RX_HEAVY_STALL: stall_pct = 71;
        TX_HEAVY_GAPS:  stall_pct = 11;
        default:        stall_pct = 0;
      endcase
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic seg_t seg_at(int x0, int y0, int x1, int y1);
    seg_t s;
    s.x_start = COORD_W'(x0);
    s.y_start = COORD_W'(y0);
    s.x_end   = COORD_W'(x1);
    s.y_end   = COORD_W'(y1);
    return s;
  endfunction

  // Straight or diagonal line from (x0, y0), length clipped at the grid edge.
  function automatic seg_t line_from(int x0, int y0, int len, heading_e dir);
    int sx, sy, span;
    sx = 0;
    sy = 0;
    case (dir)
      EAST:       sx = 1;
      WEST:       sx = -1;
      NORTH:      sy = 1;
      SOUTH:      sy = -1;
      NORTH_EAST: begin sx = 1;  sy = 1;  end
      NORTH_WEST: begin sx = -1; sy = 1;  end
      SOUTH_EAST: begin sx = 1;  sy = -1; end
      default:    begin sx = -1; sy = -1; end
    endcase
    span = len;
    if (sx > 0 && span > COORD_MAX - x0) span = COORD_MAX - x0;
    if (sx < 0 && span > x0) span = x0;
    if (sy > 0 && span > COORD_MAX - y0) span = COORD_MAX - y0;
    if (sy < 0 && span > y0) span = y0;
    return seg_at(x0, y0, x0 + sx * span, y0 + sy * span);
  endfunction

  // Mostly short lines packed into a hot spot so points pile up; some long
  // lines anywhere, and some fully random end points (mostly bad slope).
  function automatic seg_t rand_segment(int hot_x, int hot_y);
    int pick;
    pick = $urandom_range(99);
    if (pick < 10)
      return seg_at($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                    $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
    if (pick < 13)
      return line_from($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                       $urandom_range(COORD_MAX), heading_e'($urandom_range(SOUTH_WEST)));
    return line_from(hot_x + $urandom_range(HOT_SPAN), hot_y + $urandom_range(HOT_SPAN),
                     $urandom_range(SHORT_LEN_MAX), heading_e'($urandom_range(SOUTH_WEST)));
  endfunction

  task automatic send_segment(seg_t s);
    int gap_pct, gap;
    in_tdata  <= s;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    case (idle_mode)
      RX_HEAVY_STALL: gap_pct = 11;
      TX_HEAVY_GAPS:  gap_pct = 71;
      default:        gap_pct = 0;
    endcase
    gap = 0;
    while ($urandom_range(99) < gap_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic run_random(idle_mode_e mode, bit with_hold);
    int hot_x, hot_y;
    idle_mode = mode;
    hot_x = $urandom_range(COORD_MAX - HOT_SPAN);
    hot_y = $urandom_range(COORD_MAX - HOT_SPAN);
    // receiver blocks for a long stretch while segments keep coming
    if (with_hold) hold_request = 1'b1;
    repeat (SEGMENTS_PER_RUN) send_segment(rand_segment(hot_x, hot_y));
    wait_results_done();
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // single points at two corners
    send_segment(seg_at(0, 0, 0, 0));
    send_segment(seg_at(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    // full row three times: overlap, then counters held at saturation
    send_segment(seg_at(0, 0, COORD_MAX, 0));
    send_segment(seg_at(COORD_MAX, 0, 0, 0));
    send_segment(seg_at(0, 0, COORD_MAX, 0));
    // full column, main diagonal, anti-diagonal in both directions, short column and diagonal
    send_segment(seg_at(COORD_MAX, COORD_MAX, COORD_MAX, 0));
    send_segment(seg_at(0, 0, COORD_MAX, COORD_MAX));
    send_segment(seg_at(0, COORD_MAX, COORD_MAX, 0));
    send_segment(seg_at(COORD_MAX, 0, 0, COORD_MAX));
    send_segment(seg_at(5, 9, 5, 2));
    send_segment(seg_at(8, 3, 2, 9));
    // bad slope, then a single point in the middle, short and long diagonals and a row
    send_segment(seg_at(0, 0, COORD_MAX, 1));
    send_segment(seg_at(1, 2, 3, 7));
    send_segment(seg_at(COORD_MAX, COORD_MAX, 0, COORD_MAX - 1));
    send_segment(seg_at(COORD_MAX, 0, 0, 'h155));
    send_segment(seg_at(512, 512, 512, 512));
    send_segment(seg_at(512, 512, 515, 515));
    send_segment(seg_at(1, 0, 0, 1));
    send_segment(seg_at(0, 1, 1, 0));
    send_segment(seg_at('h2AA, 'h155, 'h155, 'h2AA));
    send_segment(seg_at('h155, 'h2AA, 'h2AA, 'h2AA));
    wait_results_done();

    run_random(RX_HEAVY_STALL, 1'b0);
    run_random(TX_HEAVY_GAPS, 1'b0);
    run_random(NO_IDLE, 1'b1);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
